@@ rtl/jaf_pkg.sv @@
// shared types and constants of the joystick autofire controller
package jaf_pkg;

   localparam int unsigned SHOT_BITS = 8;
   localparam int unsigned DELAY_BITS = 8;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_CENTER = 2'd0;
   localparam axis_type AXIS_NEG = 2'd1;
   localparam axis_type AXIS_POS = 2'd2;

   typedef enum logic [3:0] {
      ACT_UP           = 4'd0,
      ACT_DOWN         = 4'd1,
      ACT_LEFT         = 4'd2,
      ACT_RIGHT        = 4'd3,
      ACT_RELEASE_X    = 4'd4,
      ACT_RELEASE_Y    = 4'd5,
      ACT_RELEASE_BOTH = 4'd6,
      ACT_FIRE_PRESS   = 4'd7,
      ACT_FIRE_RELEASE = 4'd8
   } action_type;

   typedef enum logic {
      CMD_ACTION = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      CSR_PORT_SELECT     = 3'd0,
      CSR_AUTOFIRE_ENABLE = 3'd1,
      CSR_BURST_MODE      = 3'd2,
      CSR_BURST_SHOTS     = 3'd3,
      CSR_FIRE_DELAY      = 3'd4
   } csr_index_type;

   localparam logic [SHOT_BITS-1:0] BURST_SHOTS_RESET = 8'd3;
   localparam logic [DELAY_BITS-1:0] FIRE_DELAY_RESET = 8'd4;

   typedef struct packed {
      logic                  port_select;
      logic                  autofire_enable;
      logic                  burst_mode;
      logic [SHOT_BITS-1:0]  burst_shots;
      logic [DELAY_BITS-1:0] fire_delay;
   } cfg_type;

   typedef struct packed {
      logic [7:0] port_bits;
      logic [7:0] fire_bits;
      logic       bad_action;
   } result_type;

endpackage

@@ rtl/jaf_csr.sv @@
// configuration registers of the joystick autofire controller
module jaf_csr
   import jaf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [2:0] wr_index,
   input  logic [7:0] wr_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_PORT_SELECT:     cfg_in.port_select = wr_data[0];
            CSR_AUTOFIRE_ENABLE: cfg_in.autofire_enable = wr_data[0];
            CSR_BURST_MODE:      cfg_in.burst_mode = wr_data[0];
            CSR_BURST_SHOTS:     cfg_in.burst_shots = wr_data;
            CSR_FIRE_DELAY:      cfg_in.fire_delay = wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.port_select <= 1'b0;
         cfg_ff.autofire_enable <= 1'b0;
         cfg_ff.burst_mode <= 1'b0;
         cfg_ff.burst_shots <= BURST_SHOTS_RESET;
         cfg_ff.fire_delay <= FIRE_DELAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/jaf_core.sv @@
// stick and autofire state with its per-item update and result encoding
module jaf_core
   import jaf_pkg::*;
#(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       cmd,
   input  logic [3:0] action,
   input  cfg_type    cfg,
   output result_type result
);

   axis_type              axis_x_ff, axis_x_in;
   axis_type              axis_y_ff, axis_y_in;
   logic                  fire_ff, fire_in;
   logic [SHOT_BITS-1:0]  shots_ff, shots_in;
   logic                  endless_ff, endless_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [FRAME_BITS-1:0] press_ff, press_in;
   logic [FRAME_BITS-1:0] release_ff, release_in;

   logic                  firing;
   logic [FRAME_BITS-1:0] delay_ext;
   logic [FRAME_BITS-1:0] frame_plus_delay;
   logic                  press_hit;
   logic                  release_hit;
   logic [SHOT_BITS-1:0]  shots_dec;
   logic                  bad;
   logic [3:0]            nibble;

   assign firing = (shots_ff != '0) || endless_ff;
   assign delay_ext = {{(FRAME_BITS-DELAY_BITS){1'b0}}, cfg.fire_delay};
   assign frame_plus_delay = frame_ff + delay_ext;
   assign press_hit = (frame_ff == press_ff);
   // a press on this frame schedules the release at frame + delay
   assign release_hit = press_hit ? (cfg.fire_delay == '0) : (frame_ff == release_ff);
   assign shots_dec = shots_ff - SHOT_BITS'(1);

   always_comb begin
      axis_x_in = axis_x_ff;
      axis_y_in = axis_y_ff;
      fire_in = fire_ff;
      shots_in = shots_ff;
      endless_in = endless_ff;
      frame_in = frame_ff;
      press_in = press_ff;
      release_in = release_ff;
      bad = 1'b0;
      if (cmd_type'(cmd) == CMD_TICK) begin
         frame_in = frame_ff + FRAME_BITS'(1);
         if (firing) begin
            if (press_hit) begin
               fire_in = 1'b1;
               release_in = frame_plus_delay;
            end
            if (release_hit) begin
               fire_in = 1'b0;
               if (!endless_ff) begin
                  shots_in = shots_dec;
               end
               if (endless_ff || (shots_dec != '0)) begin
                  press_in = frame_plus_delay;
               end else begin
                  shots_in = '0;
                  endless_in = 1'b0;
                  press_in = '0;
                  release_in = '0;
               end
            end
         end
      end else begin
         case (action_type'(action))
            ACT_UP:           axis_y_in = AXIS_NEG;
            ACT_DOWN:         axis_y_in = AXIS_POS;
            ACT_LEFT:         axis_x_in = AXIS_NEG;
            ACT_RIGHT:        axis_x_in = AXIS_POS;
            ACT_RELEASE_X:    axis_x_in = AXIS_CENTER;
            ACT_RELEASE_Y:    axis_y_in = AXIS_CENTER;
            ACT_RELEASE_BOTH: begin
               axis_x_in = AXIS_CENTER;
               axis_y_in = AXIS_CENTER;
            end
            ACT_FIRE_PRESS: begin
               if (!cfg.autofire_enable) begin
                  fire_in = 1'b1;
               end else if (firing && !cfg.burst_mode) begin
                  // stop continuous firing
                  fire_in = 1'b0;
                  shots_in = '0;
                  endless_in = 1'b0;
                  press_in = '0;
                  release_in = '0;
               end else begin
                  // reload, and start if not yet running
                  shots_in = cfg.burst_mode ? cfg.burst_shots : '0;
                  endless_in = !cfg.burst_mode;
                  if (!firing) begin
                     fire_in = 1'b1;
                     release_in = frame_plus_delay;
                  end
               end
            end
            ACT_FIRE_RELEASE: begin
               if (!cfg.autofire_enable) begin
                  fire_in = 1'b0;
               end
            end
            default: bad = 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_x_ff <= AXIS_CENTER;
         axis_y_ff <= AXIS_CENTER;
         fire_ff <= 1'b0;
         shots_ff <= '0;
         endless_ff <= 1'b0;
         frame_ff <= '0;
         press_ff <= '0;
         release_ff <= '0;
      end else if (step) begin
         axis_x_ff <= axis_x_in;
         axis_y_ff <= axis_y_in;
         fire_ff <= fire_in;
         shots_ff <= shots_in;
         endless_ff <= endless_in;
         frame_ff <= frame_in;
         press_ff <= press_in;
         release_ff <= release_in;
      end
   end

   // result reflects the state after this item
   assign nibble = ~{axis_x_in == AXIS_POS, axis_x_in == AXIS_NEG,
                     axis_y_in == AXIS_POS, axis_y_in == AXIS_NEG};

   always_comb begin
      result.port_bits = cfg.port_select ? {nibble, 4'hF} : {4'hF, nibble};
      result.fire_bits = 8'hFF;
      if (fire_in) begin
         if (cfg.port_select) begin
            result.fire_bits[5] = 1'b0;
         end else begin
            result.fire_bits[4] = 1'b0;
         end
      end
      result.bad_action = bad;
   end

endmodule

@@ rtl/joystick_autofire_controller.sv @@
// joystick autofire controller top level
//
// Items enter on req_ (req_cmd: 0 stick or fire action, 1 end-of-frame tick;
// req_action: action code) and leave on rsp_ with the active-low direction
// nibble, the active-low fire bit and a flag for an unknown action code.
// One result comes back for every item, in order.
// An accepted item sits in the input register until the result register
// can take it; its state update runs as it moves into the result register,
// and rsp_valid rises when the result register loads.
// Throughput is one item per cycle while rsp_stall is low; the state
// update is a single pass of compares and FRAME_BITS-wide adds between
// the two registers.
// Registers are written through csr_ (csr_ready is always high); write them
// only while no item is in flight.
// Reset empties both registers, centers the stick, stops autofire, zeroes
// the frame counter and loads the register defaults.
// When rsp_stall holds the result register, the input register still takes
// one more item; after that req_stall rises until the result is taken.
module joystick_autofire_controller
   import jaf_pkg::*;
#(
   parameter int unsigned FRAME_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_cmd,
   input  logic [3:0] req_action,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_port_bits,
   output logic [7:0] rsp_fire_bits,
   output logic       rsp_bad_action,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [3:0] in_action_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   result_type core_res;
   cfg_type    cfg;
   logic       advance;
   logic       req_take;

   assign csr_ready = 1'b1;

   jaf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   jaf_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cmd    (in_cmd_ff),
      .action (in_action_ff),
      .cfg    (cfg),
      .result (core_res)
   );

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff <= req_cmd;
         in_action_ff <= req_action;
      end
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_port_bits = out_res_ff.port_bits;
   assign rsp_fire_bits = out_res_ff.fire_bits;
   assign rsp_bad_action = out_res_ff.bad_action;

endmodule

@@ rtl/jaf_checker.sv @@
// port-level checks of the joystick autofire controller and their binding
module jaf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_port_bits,
   input logic [7:0] rsp_fire_bits,
   input logic       rsp_bad_action
);

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_port_bits)
         && $stable(rsp_fire_bits) && $stable(rsp_bad_action))
      else $error("result changed while stalled");

   // only one of the two fire bits can be low, all others high
   a_fire_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fire_bits[3:0] == 4'hF && rsp_fire_bits[7:6] == 2'b11
         && (rsp_fire_bits[4] || rsp_fire_bits[5]))
      else $error("bad fire bits");

   // one idle nibble, and no opposite directions at once
   a_port_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_port_bits[7:4] == 4'hF || rsp_port_bits[3:0] == 4'hF)
         && (rsp_port_bits[0] || rsp_port_bits[1])
         && (rsp_port_bits[2] || rsp_port_bits[3])
         && (rsp_port_bits[4] || rsp_port_bits[5])
         && (rsp_port_bits[6] || rsp_port_bits[7]))
      else $error("bad direction bits");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind joystick_autofire_controller jaf_checker u_jaf_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_port_bits  (rsp_port_bits),
   .rsp_fire_bits  (rsp_fire_bits),
   .rsp_bad_action (rsp_bad_action)
);
